// File: src/bam_pkg.sv
`default_nettype none

package bam_pkg;

  localparam int unsigned MAX_PATTERN   = 64;
  localparam int unsigned MAX_ERRORS    = 8;
  localparam int unsigned POSITION_BITS = 32;

  localparam int unsigned LEVELS = MAX_ERRORS + 1;
  localparam int unsigned VEC_W  = 64;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned LVL_W  = 4;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_TEXT    = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PATTERN_LENGTH = 1'b0;
  localparam logic CFG_MAX_ERRORS     = 1'b1;

  typedef struct packed {
    logic text;
    logic restart;
  } bam_ctrl_t;

  typedef struct packed {
    logic                     hit;
    logic [LVL_W-1:0]         err;
    logic [POSITION_BITS-1:0] start_pos;
    logic [POSITION_BITS-1:0] end_pos;
  } bam_result_t;

  // Initial vector of level d: top d bits set
  function automatic logic [VEC_W-1:0] init_vector(input int unsigned d);
    logic [VEC_W-1:0] v;
    if (d == 0) begin
      v = '0;
    end else begin
      v = ~(VEC_W'(0)) << (VEC_W - d);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/bam_pattern_store.sv
`default_nettype none

module bam_pattern_store (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [bam_pkg::IDX_W-1:0]  wr_idx_i,
  input  wire logic [7:0]                 wr_byte_i,
  input  wire logic [7:0]                 text_byte_i,
  input  wire logic [bam_pkg::LEN_W-1:0]  m_eff_i,
  output logic      [bam_pkg::VEC_W-1:0]  cmask_o
);
  import bam_pkg::*;

  logic [7:0] pat_q [MAX_PATTERN];

  // Pattern bytes hold no reset: entries at or above m are never used; the user must write the others before use
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q[wr_idx_i] <= wr_byte_i;
    end
  end

  // Position i maps to bit 63-i; lanes at or above m stay clear
  always_comb begin
    cmask_o = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cmask_o[VEC_W-1-i] = (LEN_W'(i) < m_eff_i) && (pat_q[i] == text_byte_i);
    end
  end

endmodule

`default_nettype wire

// File: src/bam_vector_unit.sv
`default_nettype none

module bam_vector_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bam_pkg::bam_ctrl_t        ctrl_i,
  input  wire logic [bam_pkg::VEC_W-1:0] cmask_i,
  input  wire logic [bam_pkg::LEN_W-1:0] m_eff_i,
  input  wire logic [bam_pkg::LVL_W-1:0] k_eff_i,
  output bam_pkg::bam_result_t           result_o
);
  import bam_pkg::*;

  localparam logic [VEC_W-1:0] TopBit = {1'b1, {(VEC_W-1){1'b0}}};

  logic [VEC_W-1:0]         vec_q   [LEVELS];
  logic [VEC_W-1:0]         vec_new [LEVELS];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LEVELS-1:0]        hit;
  logic [LEN_W-1:0]         succ_w, m_less1;
  logic [IDX_W-1:0]         succ_idx;

  // One step of the k-error recurrence per level
  always_comb begin
    vec_new[0] = ((vec_q[0] >> 1) | TopBit) & cmask_i;
    for (int d = 1; d < LEVELS; d++) begin
      vec_new[d] = (((vec_q[d] >> 1) | TopBit) & cmask_i)
                 | (vec_q[d-1] >> 1) | TopBit
                 | (vec_new[d-1] >> 1)
                 | vec_q[d-1];
    end
  end

  assign succ_w   = LEN_W'(MAX_PATTERN) - m_eff_i;
  assign succ_idx = succ_w[IDX_W-1:0];
  assign m_less1  = m_eff_i - LEN_W'(1);

  always_comb begin
    for (int d = 0; d < LEVELS; d++) begin
      hit[d] = vec_new[d][succ_idx];
    end
  end

  always_comb begin
    result_o.hit = hit[k_eff_i];
    result_o.err = k_eff_i;
    for (int d = LEVELS - 1; d >= 0; d--) begin
      if (hit[d] && (LVL_W'(d) <= k_eff_i)) begin
        result_o.err = LVL_W'(d);
      end
    end
    result_o.end_pos = pos_q;
    if (pos_q >= POSITION_BITS'(m_less1)) begin
      result_o.start_pos = pos_q - POSITION_BITS'(m_less1);
    end else begin
      result_o.start_pos = '0;
    end
  end

  // Saturate the position at its top value
  assign pos_d = (pos_q != {POSITION_BITS{1'b1}}) ? pos_q + POSITION_BITS'(1) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < LEVELS; d++) begin
        vec_q[d] <= init_vector(d);
      end
      pos_q <= '0;
    end else if (ctrl_i.restart) begin
      for (int d = 0; d < LEVELS; d++) begin
        vec_q[d] <= init_vector(d);
      end
      pos_q <= '0;
    end else if (ctrl_i.text) begin
      for (int d = 0; d < LEVELS; d++) begin
        vec_q[d] <= vec_new[d];
      end
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// File: src/bitap_approximate_matcher_core.sv
`default_nettype none

// Streaming approximate matcher, up to k edit errors.
// Input stream: tuser carries the operation (text byte, pattern write,
// restart); tdata carries the byte and the pattern index. Each text byte
// advances all error vectors; when level k holds the success bit, one
// request appears on the output stream with start, end and least errors.
// Pattern writes, restarts and non-matching text bytes give no output.
// An accepted request is held in the input register; once the output
// register is free or draining it is processed and a match is loaded
// into the output register. Throughput is one request per cycle while
// the receiver does not stall; the single pass through the pattern
// comparators and the nine-level vector chain sets that figure.
// When the receiver stalls, the held result stays put; one further request
// may enter the input register, after which tready drops until the output
// drains.
// Reset (async, active low) empties both registers, sets m to 1 and k to 0,
// loads the initial vectors and clears the text position. Pattern bytes
// keep no reset and must be written before use. Configure only when idle.
module bitap_approximate_matcher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_wdata_i,
  // Input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // data_byte[7:0], pattern_index[13:8], zero pad
  input  wire logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  // Output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o   // match_start[31:0], match_end[63:32],
                                            // error_count[67:64], zero pad
);
  import bam_pkg::*;

  // Configuration registers
  logic [LEN_W-1:0] len_q;
  logic [LVL_W-1:0] errs_q;
  logic [LEN_W-1:0] m_eff;
  logic [LVL_W-1:0] k_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(1);
      errs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: len_q  <= cfg_wdata_i[LEN_W-1:0];
        CFG_MAX_ERRORS:     errs_q <= cfg_wdata_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp m into 1..MAX_PATTERN and k to MAX_ERRORS
  always_comb begin
    if (len_q == '0) begin
      m_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN)) begin
      m_eff = LEN_W'(MAX_PATTERN);
    end else begin
      m_eff = len_q;
    end
    k_eff = (errs_q > LVL_W'(MAX_ERRORS)) ? LVL_W'(MAX_ERRORS) : errs_q;
  end

  // Input register
  logic             in_valid_q;
  logic [1:0]       in_op_q;
  logic [7:0]       in_byte_q;
  logic [IDX_W-1:0] in_idx_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_take;

  // Process the held request once the output register can take a result
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i[7:0];
      in_idx_q  <= s_axis_tdata_i[13:8];
    end
  end

  // Decode the held operation; code 3 does nothing
  bam_ctrl_t ctrl;
  logic      pat_wr;

  always_comb begin
    ctrl   = '0;
    pat_wr = 1'b0;
    case (in_op_q)
      OP_TEXT:    ctrl.text    = advance;
      OP_PATTERN: pat_wr       = advance;
      OP_RESTART: ctrl.restart = advance;
      default: ;
    endcase
  end

  logic [VEC_W-1:0] cmask;
  bam_result_t      result;

  bam_pattern_store u_store (
    .clk_i       (clk_i),
    .wr_en_i     (pat_wr),
    .wr_idx_i    (in_idx_q),
    .wr_byte_i   (in_byte_q),
    .text_byte_i (in_byte_q),
    .m_eff_i     (m_eff),
    .cmask_o     (cmask)
  );

  bam_vector_unit u_vec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmask_i  (cmask),
    .m_eff_i  (m_eff),
    .k_eff_i  (k_eff),
    .result_o (result)
  );

  // Output register
  logic                     load_out;
  logic [POSITION_BITS-1:0] start_q, end_q;
  logic [LVL_W-1:0]         err_q;

  assign load_out = ctrl.text && result.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      start_q <= result.start_pos;
      end_q   <= result.end_pos;
      err_q   <= result.err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, err_q, end_q, start_q};

  // A result is only loaded when the output slot is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over a stalled result");

  // Reported error level never exceeds the clamped k
  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (err_q <= k_eff))
    else $error("error_count above max_errors");

  // Start never lies past the end
  a_start_le_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (start_q <= end_q))
    else $error("match_start beyond match_end");

  // Input stage stalls only while it holds a request
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

// Self-checking bench for the streaming bitap matcher.
// A queue of pending requests feeds a driver that toggles at the falling edge;
// a monitor samples both streams at the rising edge. Every accepted request
// runs through a local bit-vector predictor which queues the match it
// should produce; each output request is compared field by field with the
// oldest queued match.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  // Operation code that the block must ignore
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;
  localparam int unsigned IDLE_LIMIT   = 1000;
  // Margin for a non-matching request still in flight
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 12;

  localparam int unsigned LEN_TAB [NUM_PHASES] = '{0, 64, 127, 5, 2, 8, 100, 16, 4, 1, 33, 6};
  localparam int unsigned ERR_TAB [NUM_PHASES] = '{0, 8, 15, 1, 2, 3, 12, 2, 5, 0, 4, 9};
  localparam int unsigned PCT_TAB [4]          = '{0, 10, 30, 60};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [5:0] idx;
  } scan_req_t;

  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [3:0]  err;
  } match_t;

  // DUT ports; every input starts at a known value
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = CFG_PATTERN_LENGTH;
  logic [6:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = '0;  // data_byte[7:0], pattern_index[13:8], zero pad
  logic [1:0]  s_axis_tuser_i  = OP_TEXT;  // operation[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;  // match_start[31:0], match_end[63:32], error_count[67:64]

  // Predictor state, updated on every accepted request
  logic [7:0]  pat_mem [MAX_PATTERN];
  logic [63:0] lvl_vec [LEVELS];
  logic [31:0] text_pos;
  logic [6:0]  len_reg;
  logic [3:0]  err_reg;

  // Pattern as the stimulus generator sees it (runs ahead of the predictor)
  logic [7:0]  gen_pat [MAX_PATTERN];

  scan_req_t   req_q [$];
  match_t      match_q [$];

  int unsigned pushed_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned item_cnt      = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned n_text        = 0;
  int unsigned n_pattern     = 0;
  int unsigned n_restart     = 0;
  int unsigned n_unused      = 0;
  int unsigned n_settings    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned send_gap      = 0;
  int unsigned stall_cnt     = 0;
  logic        calm          = 1'b0;
  logic        req_taken     = 1'b0;

  bitap_approximate_matcher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp the length register into 1..MAX_PATTERN
  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_PATTERN) return MAX_PATTERN;
    return len_reg;
  endfunction

  // Load the start-of-text vectors: level d has its top d bits set
  function automatic void restart_text();
    int unsigned d;
    for (d = 0; d < LEVELS; d++) begin
      lvl_vec[d] = (d == 0) ? 64'd0 : (~64'd0 << (64 - d));
    end
    text_pos = '0;
  endfunction

  // Advance the predictor by one request and queue the match it produces
  function automatic void scan_request(input scan_req_t rq);
    int unsigned m, k, d, i, lvl;
    logic [63:0] cmask, hit_bit, prev_old, prev_new, old_v, nv;
    logic [31:0] pos;
    match_t      mt;
    case (rq.op)
      OP_PATTERN: begin
        pat_mem[rq.idx] = rq.data;
      end
      OP_RESTART: begin
        restart_text();
      end
      OP_TEXT: begin
        m = eff_len();
        k = (err_reg > MAX_ERRORS) ? MAX_ERRORS : err_reg;
        cmask = '0;
        for (i = 0; i < m; i++) begin
          if (pat_mem[i] == rq.data) cmask[63-i] = 1'b1;
        end
        // Exact level first, then each error level from its old and new neighbor
        prev_old   = lvl_vec[0];
        lvl_vec[0] = ((prev_old >> 1) | TOP_BIT) & cmask;
        prev_new   = lvl_vec[0];
        for (d = 1; d < LEVELS; d++) begin
          old_v = lvl_vec[d];
          nv = (((old_v >> 1) | TOP_BIT) & cmask)
             | ((prev_old >> 1) | TOP_BIT)
             | ((prev_new >> 1) | TOP_BIT)
             | prev_old;
          lvl_vec[d] = nv;
          prev_old   = old_v;
          prev_new   = nv;
        end
        pos = text_pos;
        if (text_pos != '1) text_pos = text_pos + 1;
        hit_bit = 64'd1 << (64 - m);
        if ((lvl_vec[k] & hit_bit) != 0) begin
          lvl = 0;
          while (lvl < k && (lvl_vec[lvl] & hit_bit) == 0) lvl++;
          mt.start_pos = (pos >= m - 1) ? pos - (m - 1) : 32'd0;
          mt.end_pos   = pos;
          mt.err       = 4'(lvl);
          match_q.push_back(mt);
        end
      end
      default: begin
        // unused operation: no state change, no match
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending request, holding it until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    scan_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !req_taken) begin
      // hold the current request
    end else if (send_gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (req_q.size() != 0 && !calm && $urandom_range(0, 99) < gap_pct) begin
      // open a burst of idle cycles
      s_axis_tvalid_i <= 1'b0;
      send_gap <= $urandom_range(0, 7);
    end else if (req_q.size() != 0) begin
      nxt = req_q.pop_front();
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {2'b00, nxt.idx, nxt.data};
      s_axis_tuser_i  <= nxt.op;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Receiver: stall in random bursts
  always @(negedge clk_i) begin
    if (stall_cnt != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      m_axis_tready_i <= 1'b0;
      stall_cnt <= $urandom_range(0, 7);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, then feed accepted requests to the predictor
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    scan_req_t rq;
    match_t    got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.start_pos = m_axis_tdata_o[31:0];
      got.end_pos   = m_axis_tdata_o[63:32];
      got.err       = m_axis_tdata_o[67:64];
      if (match_q.size() == 0) begin
        $display("%0t ns: unexpected match, expected none, got start %0d end %0d errors %0d",
                 $time, got.start_pos, got.end_pos, got.err);
        mismatch_cnt++;
      end else begin
        want = match_q.pop_front();
        check_field("match_start", want.start_pos, got.start_pos);
        check_field("match_end", want.end_pos, got.end_pos);
        check_field("error_count", 32'(want.err), 32'(got.err));
        checked_cnt++;
      end
    end
    req_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      rq.op   = s_axis_tuser_i;
      rq.data = s_axis_tdata_i[7:0];
      rq.idx  = s_axis_tdata_i[13:8];
      scan_request(rq);
      accepted_cnt++;
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: watchdog fired, %0d matches still awaited, %0d requests unsent",
               $time, match_q.size(), pushed_cnt - accepted_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op, input logic [7:0] data,
                          input logic [5:0] idx);
    scan_req_t rq;
    rq.op   = op;
    rq.data = data;
    rq.idx  = idx;
    req_q.push_back(rq);
    pushed_cnt++;
    case (op)
      OP_TEXT:    n_text++;
      OP_PATTERN: n_pattern++;
      OP_RESTART: n_restart++;
      default:    n_unused++;
    endcase
    if (op != OP_UNUSED) item_cnt++;
  endtask

  // Wait at a falling edge until everything sent is accepted and every match
  // has arrived, then let a non-matching request in flight clear the pipeline
  task automatic settle();
    while (accepted_cnt != pushed_cnt || match_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write both registers; only called from a falling edge with the block idle
  task automatic configure(input logic [6:0] len_val, input logic [6:0] err_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PATTERN_LENGTH;
    cfg_wdata_i <= len_val;
    len_reg = len_val;
    @(negedge clk_i);
    cfg_index_i <= CFG_MAX_ERRORS;
    cfg_wdata_i <= err_val;
    err_reg = err_val[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // One phase of random traffic: mostly copies of the pattern with a few
  // edits, plus noise, restarts, ignored requests and pattern rewrites
  task automatic run_phase(input int unsigned n_items);
    int unsigned m, r, e, i, j, n, stop;
    logic [7:0]  sym [4];
    logic [5:0]  wi;
    m = eff_len();
    for (j = 0; j < 4; j++) sym[j] = 8'($urandom);
    // Narrow the alphabet now and then so partial matches are common
    if ($urandom_range(0, 2) == 0) sym[2] = sym[0];
    for (i = 0; i < m; i++) begin
      gen_pat[i] = sym[$urandom_range(0, 3)];
      push_req(OP_PATTERN, gen_pat[i], 6'(i));
    end
    stop = item_cnt + n_items;
    while (item_cnt < stop) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        for (i = 0; i < m; i++) begin
          e = $urandom_range(0, m + 3);
          if (e == 0) begin
            push_req(OP_TEXT, sym[$urandom_range(0, 3)], 6'($urandom));
          end else if (e == 1) begin
            // drop this byte
          end else if (e == 2) begin
            push_req(OP_TEXT, sym[$urandom_range(0, 3)], 6'($urandom));
            push_req(OP_TEXT, gen_pat[i], 6'($urandom));
          end else begin
            push_req(OP_TEXT, gen_pat[i], 6'($urandom));
          end
        end
      end else if (r < 75) begin
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) push_req(OP_TEXT, sym[$urandom_range(0, 3)], 6'($urandom));
      end else if (r < 85) begin
        push_req(OP_TEXT, 8'($urandom), 6'($urandom));
      end else if (r < 90) begin
        push_req(OP_RESTART, 8'($urandom), 6'($urandom));
      end else if (r < 94) begin
        push_req(OP_UNUSED, 8'($urandom), 6'($urandom));
      end else begin
        wi = 6'($urandom);
        gen_pat[wi] = sym[$urandom_range(0, 3)];
        push_req(OP_PATTERN, gen_pat[wi], wi);
      end
    end
  endtask

  initial begin
    int unsigned     i, p;
    logic [7:0]      b;

    // Predictor matches the block's reset state
    len_reg = 7'd1;
    err_reg = 4'd0;
    restart_text();

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load every pattern byte before any text byte reads one
    for (i = 0; i < MAX_PATTERN; i++) begin
      b = (i == 0) ? 8'hFF : (i == MAX_PATTERN - 1) ? 8'h00 : 8'($urandom);
      gen_pat[i] = b;
      push_req(OP_PATTERN, b, 6'(i));
    end

    // Reset settings (m = 1, k = 0): hit, miss, ignored op, restart, rewrite
    push_req(OP_TEXT, 8'hFF, 6'h3F);
    push_req(OP_TEXT, 8'h00, 6'h00);
    push_req(OP_UNUSED, 8'hFF, 6'h3F);
    push_req(OP_TEXT, 8'hFF, 6'h00);
    push_req(OP_RESTART, 8'h00, 6'h00);
    push_req(OP_TEXT, 8'hFF, 6'h00);
    push_req(OP_PATTERN, 8'h5A, 6'h00);
    push_req(OP_TEXT, 8'h5A, 6'h00);
    settle();

    // Three-byte pattern, one error: exact, insertion, deletion, substitution
    configure(7'd3, 7'd1);
    push_req(OP_PATTERN, "a", 6'd0);
    push_req(OP_PATTERN, "b", 6'd1);
    push_req(OP_PATTERN, "c", 6'd2);
    push_req(OP_TEXT, "a", 6'd0);
    push_req(OP_TEXT, "b", 6'd0);
    push_req(OP_TEXT, "c", 6'd0);
    push_req(OP_RESTART, 8'h00, 6'd0);
    push_req(OP_TEXT, "a", 6'd0);
    push_req(OP_TEXT, "b", 6'd0);
    push_req(OP_TEXT, "x", 6'd0);
    push_req(OP_TEXT, "c", 6'd0);
    push_req(OP_RESTART, 8'h00, 6'd0);
    push_req(OP_TEXT, "a", 6'd0);
    push_req(OP_TEXT, "c", 6'd0);
    push_req(OP_RESTART, 8'h00, 6'd0);
    push_req(OP_TEXT, "a", 6'd0);
    push_req(OP_TEXT, "x", 6'd0);
    push_req(OP_TEXT, "c", 6'd0);
    for (i = 0; i < 3; i++) gen_pat[i] = 8'("a") + 8'(i);
    // Sender waits here for every match before the registers change
    settle();

    // Random phases over a spread of lengths and error limits, the
    // out-of-range register values among them; the last phase runs flat out
    for (p = 0; p < NUM_PHASES; p++) begin
      configure(7'(LEN_TAB[p]), {3'($urandom), 4'(ERR_TAB[p])});
      if (p == NUM_PHASES - 1) begin
        calm      = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
      end else if (p == 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = PCT_TAB[$urandom_range(0, 3)];
        stall_pct = PCT_TAB[$urandom_range(0, 3)];
      end
      run_phase(PHASE_ITEMS);
      settle();
    end

    $display("Run covered %0d text bytes, %0d pattern writes, %0d restarts, %0d ignored ops",
             n_text, n_pattern, n_restart, n_unused);
    $display("over %0d register settings; %0d matches compared, %0d mismatches",
             n_settings, checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: bitap_approximate_matcher_core.f
src/bam_pkg.sv
src/bam_pattern_store.sv
src/bam_vector_unit.sv
src/bitap_approximate_matcher_core.sv
sim/tb_top.sv
